[rtl/ipv4sb_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4sb_pkg
// Shared types and constants for the IPv4 source blocklist.
// ----------------------------------------------------------------------------
package ipv4sb_pkg;

   localparam int ADDR_W              = 32;
   localparam int MAX_RULES_W         = 5;
   localparam int RULES_HELD_W        = 5;
   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam logic [MAX_RULES_W-1:0] MAX_RULES_RESET = 5'd10;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   typedef enum logic {
      OP_CHECK  = 1'b0,
      OP_TOGGLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_CHECK   = 2'd0,
      STATUS_ADDED   = 2'd1,
      STATUS_REMOVED = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DECIDE,
      ST_MOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic                    drop;
      status_type              status;
      logic [RULES_HELD_W-1:0] rules_held;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] address;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

[rtl/ipv4_source_blocklist.sv]
// ----------------------------------------------------------------------------
// ipv4_source_blocklist
// Blocklist of IPv4 source addresses with packet checks and rule toggles.
// ----------------------------------------------------------------------------
// Each request beat is a packet check (kind 0) or a rule toggle (kind 1) for a
// 32-bit address, first octet in the top byte. A check answers drop when any
// stored rule equals the address. A toggle removes an equal rule, moving the
// last rule into its slot, or else appends the address, reporting table full
// once the count has reached max_rules (saturated at TABLE_DEPTH). Rules live
// in a single-port-read RAM that is scanned one entry at a time, each entry
// read (ST_READ) and then compared (ST_CMP); a removal adds a move step
// (ST_MOVE). The scan stops at the first match. A two-beat command queue
// keeps taking requests while a scan runs, and a registered response beat
// may wait under rsp_stall without holding up the next scan. The rule RAM
// needs no clearing after reset: only entries below the count are ever read.
// max_rules resets to ten.
// ----------------------------------------------------------------------------
module ipv4_source_blocklist #(
   parameter int TABLE_DEPTH = ipv4sb_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ipv4sb_pkg::req_type                req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ipv4sb_pkg::rsp_type                rsp_data,
   // max_rules register
   input  logic                               csr_wr_en,
   input  logic [ipv4sb_pkg::MAX_RULES_W-1:0] csr_wr_data
);
   import ipv4sb_pkg::*;

   logic [MAX_RULES_W-1:0] max_rules_ff, max_rules_in;
   queue_out_type          q_out;
   logic                   q_pop;

   // config register: only to be written by the user while the block is quiet; the block does not enforce this
   always_comb begin
      max_rules_in = csr_wr_en ? csr_wr_data : max_rules_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rules_ff <= MAX_RULES_RESET;
      end else begin
         max_rules_ff <= max_rules_in;
      end
   end

   // front: accept and decode request beats into the command queue
   ipv4sb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   // back: table scan, update and response register
   ipv4sb_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .max_rules (max_rules_ff),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   logic [31:0] lim_chk;
   assign lim_chk = (32'(max_rules_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                          : 32'(max_rules_ff);

   // only checks may ask for a drop
   a_drop_only_on_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_CHECK |-> !rsp_data.drop)
      else $error("drop set on a toggle response");

   // a full report means the count really reached the limit
   a_full_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL
      |-> (TABLE_DEPTH >= 32) || (32'(rsp_data.rules_held) >= lim_chk))
      else $error("table full reported below the limit");

   // an append never takes the count past the limit
   a_added_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ADDED
      |-> (TABLE_DEPTH >= 32) ||
          ((rsp_data.rules_held != '0) && (32'(rsp_data.rules_held) <= lim_chk)))
      else $error("rule added beyond the limit");
`endif

endmodule

[rtl/ipv4sb_ram.sv]
// ----------------------------------------------------------------------------
// ipv4sb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipv4sb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ipv4sb_front.sv]
// ----------------------------------------------------------------------------
// ipv4sb_front
// Takes request beats, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module ipv4sb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ipv4sb_pkg::req_type       req_data,
   output ipv4sb_pkg::queue_out_type q_out,
   input  logic                      q_pop
);
   import ipv4sb_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               push;
   logic               pop;
   cmd_type            cmd_new;

   assign req_stall = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (fill_ff != '0);

   always_comb begin
      cmd_new.op      = (req_data.kind == 1'b1) ? OP_TOGGLE : OP_CHECK;
      cmd_new.address = req_data.address;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         fill_in = QFILL_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = QFILL_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign q_out.valid = (fill_ff != '0);
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

endmodule

[rtl/ipv4sb_back.sv]
// ----------------------------------------------------------------------------
// ipv4sb_back
// Scans the rule RAM for each command, updates the table and registers the
// response beat.
// ----------------------------------------------------------------------------
module ipv4sb_back #(
   parameter int TABLE_DEPTH = ipv4sb_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ipv4sb_pkg::MAX_RULES_W-1:0]    max_rules,
   input  ipv4sb_pkg::queue_out_type             q_out,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ipv4sb_pkg::rsp_type                   rsp_data
);
   import ipv4sb_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              match_ff, match_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ADDR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ADDR_W-1:0] ram_rd_data;

   logic [31:0]       cnt_wide;
   logic [31:0]       last_wide;
   logic [31:0]       lim_wide;
   logic [IDX_W-1:0]  last_idx;
   logic              idx_is_last;
   logic              table_full;
   logic              hit;
   logic              out_free;

   ipv4sb_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_rules (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // limit saturates at the table depth
   always_comb begin
      cnt_wide    = 32'(count_ff);
      last_wide   = cnt_wide - 32'd1;
      last_idx    = last_wide[IDX_W-1:0];
      idx_is_last = (32'(idx_ff) == last_wide);
      lim_wide    = (32'(max_rules) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(max_rules);
      table_full  = (cnt_wide >= lim_wide);
      hit         = (ram_rd_data == cmd_ff.address);
      out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               state_in = (count_ff == '0) ? ST_DECIDE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit || idx_is_last) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DECIDE: begin
            if (cmd_ff.op == OP_TOGGLE && match_ff) begin
               state_in = ST_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      match_in     = match_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_out.cmd;
               idx_in   = '0;
               match_in = 1'b0;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
         end
         ST_CMP: begin
            if (hit) begin
               match_in = 1'b1;
               slot_in  = idx_ff;
            end else if (!idx_is_last) begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_DECIDE: begin
            case (cmd_ff.op)
               OP_CHECK: begin
                  status_in = STATUS_CHECK;
               end
               OP_TOGGLE: begin
                  if (match_ff) begin
                     // fetch the last rule to fill the vacated slot
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = last_idx;
                     status_in   = STATUS_REMOVED;
                  end else if (table_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cnt_wide[IDX_W-1:0];
                     ram_wr_data = cmd_ff.address;
                     count_in    = CNT_W'(count_ff + 1'b1);
                     status_in   = STATUS_ADDED;
                  end
               end
               default: begin
                  status_in = STATUS_CHECK;
               end
            endcase
         end
         ST_MOVE: begin
            ram_wr_en = 1'b1;
            count_in  = CNT_W'(count_ff - 1'b1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.drop       = (cmd_ff.op == OP_CHECK) && match_ff;
               rsp_in.status     = status_ff;
               rsp_in.rules_held = cnt_wide[RULES_HELD_W-1:0];
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      match_ff  <= match_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/ipv4_source_blocklist_checker.sv]
// ----------------------------------------------------------------------------
// ipv4_source_blocklist_checker
// Predicts and checks every response beat of the IPv4 source blocklist.
// ----------------------------------------------------------------------------
// Watches the request, response and max_rules ports. It keeps a copy of the
// rule table, pushes the expected verdict of each accepted request beat, and
// compares each accepted response beat against the oldest one, field by field.
// ----------------------------------------------------------------------------
module ipv4_source_blocklist_checker #(
   parameter int TABLE_DEPTH = ipv4sb_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  ipv4sb_pkg::req_type                req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  ipv4sb_pkg::rsp_type                rsp_data,
   input  logic                               csr_wr_en,
   input  logic [ipv4sb_pkg::MAX_RULES_W-1:0] csr_wr_data,
   output int                                 fail_count,
   output int                                 pending
);
   import ipv4sb_pkg::*;

   logic [ADDR_W-1:0]      rule_copy [TABLE_DEPTH];
   int unsigned            rule_total;
   logic [MAX_RULES_W-1:0] limit_reg;
   rsp_type                expected_verdicts [$];

   initial fail_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   // applies one beat to the rule copy and returns its verdict
   function automatic rsp_type apply_item(input req_type item);
      rsp_type     verdict;
      int unsigned slot;
      int unsigned limit_now;
      bit          hit;
      verdict.drop   = 1'b0;
      verdict.status = STATUS_CHECK;
      hit  = 1'b0;
      slot = 0;
      for (int i = 0; i < rule_total; i++) begin
         if (!hit && rule_copy[i] == item.address) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      // limit saturates at the table depth
      limit_now = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
      if (item.kind == OP_CHECK) begin
         verdict.drop = hit;
      end else if (hit) begin
         rule_copy[slot] = rule_copy[rule_total-1];
         rule_total--;
         verdict.status = STATUS_REMOVED;
      end else if (rule_total >= limit_now) begin
         verdict.status = STATUS_FULL;
      end else begin
         rule_copy[rule_total] = item.address;
         rule_total++;
         verdict.status = STATUS_ADDED;
      end
      verdict.rules_held = RULES_HELD_W'(rule_total);
      return verdict;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         rule_total = 0;
         limit_reg  = MAX_RULES_RESET;
         expected_verdicts.delete();
      end else begin
         if (csr_wr_en)
            limit_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.drop !== want.drop)
                  report_mismatch($sformatf("drop expected %0d got %0d",
                                            want.drop, rsp_data.drop));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, rsp_data.status));
               if (rsp_data.rules_held !== want.rules_held)
                  report_mismatch($sformatf("rules_held expected %0d got %0d",
                                            want.rules_held, rsp_data.rules_held));
            end
         end
         if (req_valid && !req_stall)
            expected_verdicts.push_back(apply_item(req_data));
      end
      pending <= expected_verdicts.size();
   end

endmodule

[dv/tb_ipv4_source_blocklist.sv]
// ----------------------------------------------------------------------------
// tb_ipv4_source_blocklist
// Stimulus and verdict for the IPv4 source blocklist.
// ----------------------------------------------------------------------------
// Drives a directed run over the table edges (empty table, both address
// extremes, removal with the last rule moved, full table, limit lowered below
// the count, zero limit, limit above the depth), then random phases under a
// range of max_rules values. Request beats come in bursts with gaps, the
// response side stalls on its own pattern. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_ipv4_source_blocklist;
   import ipv4sb_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int POOL_SIZE    = 28;
   localparam int PHASE_BEATS  = 50;
   // allow for the longest scan, the queue and a waiting beat
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 3000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [MAX_RULES_W-1:0] csr_wr_data;

   int                     fail_count;
   int                     pending;

   logic [ADDR_W-1:0]      addr_pool [POOL_SIZE];
   int                     burst_left;
   int                     idle_cycles;

   // receiver stall pattern state
   int                     stall_mode;
   int                     mode_timer;
   int                     run_left;

   ipv4_source_blocklist #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ipv4_source_blocklist_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) verdict_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: every so often pick a new mode - no stall, coin-flip stall,
   // or alternating stall and pass cycles - so stalls land on every phase of a scan.
   always @(posedge clock) begin
      if (reset) begin
         stall_mode = 0;
         mode_timer = 0;
         run_left   = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (mode_timer == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = $urandom_range(20, 150);
         end
         mode_timer--;
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if (run_left == 0)
                  run_left = $urandom_range(1, 10);
               run_left--;
               // even counts left stall three times in four, odd ones let beats through
               rsp_stall <= (run_left % 2 == 0) ? ($urandom_range(0, 3) != 0) : 1'b0;
            end
         endcase
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Presents one request beat and holds it until taken. Valid stays high
   // into the next beat unless the burst has run out.
   task automatic send_beat(input op_type op, input logic [ADDR_W-1:0] addr);
      req_valid <= 1'b1;
      req_data  <= '{kind: op, address: addr};
      do
         @(posedge clock);
      while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // an occasional long burst gives stretches with no sender gaps
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Holds the sender off until every response has come, then lets any
   // trailing scan settle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called while idle.
   task automatic write_limit(input logic [MAX_RULES_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly pool addresses so toggles and checks hit the table often.
   task automatic send_random_beat();
      int          pick;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      addr = addr_pool[$urandom_range(0, POOL_SIZE-1)];
      if (pick < 45)
         send_beat(OP_TOGGLE, addr);
      else if (pick < 85)
         send_beat(OP_CHECK, addr);
      else if (pick < 94)
         send_beat(OP_CHECK, $urandom());
      else
         send_beat(OP_TOGGLE, $urandom());
   endtask

   initial begin : stimulus
      logic [MAX_RULES_W-1:0] phase_limits [8];
      phase_limits = '{5'd16, 5'd31, 5'd2, 5'd20, 5'd0, 5'd7, 5'd1, 5'd10};

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_cycles = 0;
      burst_left  = $urandom_range(1, 12);

      // both extremes, neighbours one bit apart, the rest random
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         addr_pool[i] = $urandom();
      for (int i = 2; i < 8; i++)
         addr_pool[i+8] = addr_pool[i] ^ (32'h1 << $urandom_range(0, 31));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, limit at its reset value of ten ---
      send_beat(OP_CHECK,  32'h0000_0000);   // empty table accepts
      send_beat(OP_TOGGLE, 32'h0000_0000);
      send_beat(OP_TOGGLE, 32'hFFFF_FFFF);
      send_beat(OP_CHECK,  32'h0000_0000);
      send_beat(OP_CHECK,  32'hFFFF_FFFF);
      send_beat(OP_CHECK,  32'h7FFF_FFFF);
      send_beat(OP_TOGGLE, 32'h0000_0000);   // last rule moves into slot 0
      send_beat(OP_CHECK,  32'hFFFF_FFFF);
      send_beat(OP_CHECK,  32'h0000_0000);
      for (int i = 2; i < 11; i++)
         send_beat(OP_TOGGLE, addr_pool[i]);
      send_beat(OP_TOGGLE, 32'h8000_0001);   // table full at ten
      send_beat(OP_TOGGLE, 32'hFFFF_FFFF);   // removal still works when full
      drain_responses();

      // limit lowered below the count: rules stay, appends are refused
      write_limit(5'd3);
      send_beat(OP_TOGGLE, 32'h8000_0001);
      send_beat(OP_TOGGLE, addr_pool[4]);
      send_beat(OP_CHECK,  addr_pool[5]);
      drain_responses();

      // zero limit
      write_limit(5'd0);
      send_beat(OP_TOGGLE, 32'h8000_0001);
      send_beat(OP_TOGGLE, addr_pool[6]);
      drain_responses();

      // above the depth: fill to sixteen, then the rest are refused
      write_limit(5'd31);
      for (int i = 0; i < 12; i++)
         send_beat(OP_TOGGLE, $urandom());
      drain_responses();

      // --- random phases across the range of limits ---
      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            send_random_beat();
            // in every third phase, a mid-phase hold-off until every response is back
            if (n == PHASE_BEATS / 2 && p % 3 == 0)
               drain_responses();
         end
         drain_responses();
      end

      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
